>>> rtl/btg_pkg.sv
// Package for the BT.601 grayscale luma block: widths, coefficients and shared types.
// No dependencies; imported by btg_rgb_decode, bt601_grayscale_luma and tb_top.
package btg_pkg;

   localparam int PIX_W  = 8;
   localparam int SUM_W  = 20;
   localparam int WSUM_W = 18;
   localparam int PROD_W = 37;
   localparam int ENC_W  = 16;

   localparam int COEF_Y      = 298;
   localparam int COEF_RV     = 409;
   localparam int COEF_GU     = 100;
   localparam int COEF_GV     = 208;
   localparam int COEF_BU     = 516;
   localparam int CHROMA_OFS  = 128;
   localparam int LUMA_OFS    = 16;
   localparam int ROUND_HALF  = 128;

   localparam int WEIGHT_R    = 299;
   localparam int WEIGHT_G    = 587;
   localparam int WEIGHT_B    = 114;
   localparam int GRAY_ROUND  = 500;
   localparam int GRAY_MAX_SUM = 255500;

   localparam int RECIP_1000  = 268436;
   localparam int RECIP_SHIFT = 28;

   localparam int ENC_SCALE   = 220;
   localparam int ENC_ROUND   = 128;
   localparam int ENC_SHIFT   = 8;
   localparam int ENC_MIN     = 16;
   localparam int ENC_MAX     = 235;

   typedef struct packed {
      logic [PIX_W-1:0] r;
      logic [PIX_W-1:0] g;
      logic [PIX_W-1:0] b;
   } rgb_type;

endpackage

>>> rtl/btg_rgb_decode.sv
// Two-stage BT.601 limited-range YUV to RGB decoder with rounding and clamping.
// Depends on btg_pkg.
module btg_rgb_decode
   import btg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [PIX_W-1:0] luma,
   input  logic [PIX_W-1:0] cb_raw,
   input  logic [PIX_W-1:0] cr_raw,
   output logic             out_valid,
   output rgb_type          rgb
);

   function automatic logic [PIX_W-1:0] clamp_byte(input logic signed [SUM_W-1:0] sum);
      logic signed [SUM_W-1:0] sh;
      sh = sum >>> 8;
      if (sh < 0) begin
         return '0;
      end else if (sh > SUM_W'(255)) begin
         return '1;
      end
      return sh[PIX_W-1:0];
   endfunction

   logic signed [SUM_W-1:0] c_val, cb_val, cr_val;
   logic signed [SUM_W-1:0] sum_r_in, sum_g_in, sum_b_in;
   logic signed [SUM_W-1:0] sum_r_ff, sum_g_ff, sum_b_ff;
   logic                    v1_ff, v2_ff;
   rgb_type                 rgb_in, rgb_ff;

   always_comb begin
      c_val    = $signed(SUM_W'(luma)) - SUM_W'(LUMA_OFS);
      cb_val   = $signed(SUM_W'(cb_raw)) - SUM_W'(CHROMA_OFS);
      cr_val   = $signed(SUM_W'(cr_raw)) - SUM_W'(CHROMA_OFS);
      sum_r_in = SUM_W'(COEF_Y) * c_val + SUM_W'(COEF_RV) * cr_val + SUM_W'(ROUND_HALF);
      sum_g_in = SUM_W'(COEF_Y) * c_val - SUM_W'(COEF_GU) * cb_val
                 - SUM_W'(COEF_GV) * cr_val + SUM_W'(ROUND_HALF);
      sum_b_in = SUM_W'(COEF_Y) * c_val + SUM_W'(COEF_BU) * cb_val + SUM_W'(ROUND_HALF);
   end

   always_comb begin
      rgb_in.r = clamp_byte(sum_r_ff);
      rgb_in.g = clamp_byte(sum_g_ff);
      rgb_in.b = clamp_byte(sum_b_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      sum_r_ff <= sum_r_in;
      sum_g_ff <= sum_g_in;
      sum_b_ff <= sum_b_in;
      rgb_ff   <= rgb_in;
   end

   assign out_valid = v2_ff;
   assign rgb       = rgb_ff;

endmodule

>>> rtl/bt601_grayscale_luma.sv
// Top level of the BT.601 grayscale luma pipeline: decode, weighted gray, re-encode.
// Depends on btg_pkg and btg_rgb_decode.
//
//   Channel   Ports                                          Direction
//   request   start, busy, req_luma_in/blue_diff/red_diff    in (busy out)
//   response  rsp_strobe, rsp_gray_luma                      out
//
// Five register stages: decoder sums, decoder rgb, wsum_ff, prod_ff, gray_luma_ff.
// One pixel is taken in every cycle; busy is always low.
// Synchronous reset clears the valid bits of every stage; data registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
module bt601_grayscale_luma
   import btg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [PIX_W-1:0] req_luma_in,
   input  logic [PIX_W-1:0] req_blue_diff,
   input  logic [PIX_W-1:0] req_red_diff,
   output logic             rsp_strobe,
   output logic [PIX_W-1:0] rsp_gray_luma
);

   logic                rgb_valid;
   rgb_type             rgb;
   logic                v3_ff, v4_ff, v5_ff;
   logic [WSUM_W-1:0]   wsum_in, wsum_ff;
   logic [PROD_W-1:0]   prod_in, prod_ff;
   logic [PIX_W-1:0]    gray;
   logic [ENC_W-1:0]    enc_sum;
   logic [PIX_W-1:0]    gray_luma_in, gray_luma_ff;

   assign busy = 1'b0;

   btg_rgb_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .luma      (req_luma_in),
      .cb_raw    (req_blue_diff),
      .cr_raw    (req_red_diff),
      .out_valid (rgb_valid),
      .rgb       (rgb)
   );

   always_comb begin
      wsum_in = WSUM_W'(WEIGHT_R) * WSUM_W'(rgb.r) + WSUM_W'(WEIGHT_G) * WSUM_W'(rgb.g)
                + WSUM_W'(WEIGHT_B) * WSUM_W'(rgb.b) + WSUM_W'(GRAY_ROUND);
      prod_in = PROD_W'(wsum_ff) * PROD_W'(RECIP_1000);
      gray    = prod_ff[RECIP_SHIFT+PIX_W-1:RECIP_SHIFT];
      enc_sum = ENC_W'(ENC_SCALE) * ENC_W'(gray) + ENC_W'(ENC_ROUND);
      gray_luma_in = enc_sum[ENC_SHIFT+PIX_W-1:ENC_SHIFT] + PIX_W'(ENC_MIN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v3_ff <= rgb_valid;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      wsum_ff      <= wsum_in;
      prod_ff      <= prod_in;
      gray_luma_ff <= gray_luma_in;
   end

   assign rsp_strobe    = v5_ff;
   assign rsp_gray_luma = gray_luma_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##5 rsp_strobe)
      else $error("Transfer did not produce a result after five cycles.");

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_gray_luma >= PIX_W'(ENC_MIN) && rsp_gray_luma <= PIX_W'(ENC_MAX)))
      else $error("Result luma left the limited range.");

   a_wsum_bound: assert property (@(posedge clock) disable iff (reset)
      v4_ff |-> ($past(wsum_ff) <= WSUM_W'(GRAY_MAX_SUM)))
      else $error("Weighted gray sum exceeded its bound.");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for bt601_grayscale_luma: random and corner pixels go in,
// and each gray luma result is compared with a predictor in the bench.
// Depends on btg_pkg and the block's RTL.
module tb_top;
   import btg_pkg::*;

   typedef struct {
      logic [PIX_W-1:0] luma;
      logic [PIX_W-1:0] cb;
      logic [PIX_W-1:0] cr;
      int unsigned      idle_pct;
   } pixel_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [PIX_W-1:0] req_luma_in = '0;
   logic [PIX_W-1:0] req_blue_diff = '0;
   logic [PIX_W-1:0] req_red_diff = '0;
   logic             rsp_strobe;
   logic [PIX_W-1:0] rsp_gray_luma;

   pixel_type        pending_pixels[$];
   logic [PIX_W-1:0] gray_due[$];
   int unsigned      mismatch_count = 0;

   bt601_grayscale_luma u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_luma_in   (req_luma_in),
      .req_blue_diff (req_blue_diff),
      .req_red_diff  (req_red_diff),
      .rsp_strobe    (rsp_strobe),
      .rsp_gray_luma (rsp_gray_luma)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int clamp_to_byte(int value);
      if (value < 0) return 0;
      if (value > 255) return 255;
      return value;
   endfunction

   function automatic logic [PIX_W-1:0] gray_luma_of_pixel(logic [PIX_W-1:0] luma,
                                                          logic [PIX_W-1:0] cb_in,
                                                          logic [PIX_W-1:0] cr_in);
      int y_ofs;
      int cb;
      int cr;
      int red;
      int green;
      int blue;
      int gray;
      y_ofs = int'(luma) - LUMA_OFS;
      cb    = int'(cb_in) - CHROMA_OFS;
      cr    = int'(cr_in) - CHROMA_OFS;
      red   = clamp_to_byte((298 * y_ofs + 409 * cr + 128) >>> 8);
      green = clamp_to_byte((298 * y_ofs - 100 * cb - 208 * cr + 128) >>> 8);
      blue  = clamp_to_byte((298 * y_ofs + 516 * cb + 128) >>> 8);
      gray  = (299 * red + 587 * green + 114 * blue + 500) / 1000;
      return PIX_W'(clamp_to_byte(((220 * gray + 128) >>> 8) + 16));
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic queue_pixel(int luma, int cb, int cr, int unsigned idle_pct);
      pixel_type pix;
      pix.luma     = PIX_W'(luma);
      pix.cb       = PIX_W'(cb);
      pix.cr       = PIX_W'(cr);
      pix.idle_pct = idle_pct;
      pending_pixels.push_back(pix);
   endtask

   always @(posedge clock) begin : drive_pixels
      pixel_type next_pix;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            gray_due.push_back(gray_luma_of_pixel(req_luma_in, req_blue_diff, req_red_diff));
         end
         if (!start || !busy) begin
            if (pending_pixels.size() != 0 &&
                $urandom_range(99) >= pending_pixels[0].idle_pct) begin
               next_pix = pending_pixels.pop_front();
               start         <= 1'b1;
               req_luma_in   <= next_pix.luma;
               req_blue_diff <= next_pix.cb;
               req_red_diff  <= next_pix.cr;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_results
      logic [PIX_W-1:0] want;
      if (!reset && rsp_strobe) begin
         if (gray_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result gray_luma=%0d", rsp_gray_luma));
         end else begin
            want = gray_due.pop_front();
            if (rsp_gray_luma !== want) begin
               report_mismatch($sformatf("gray_luma got %0d want %0d", rsp_gray_luma, want));
            end
         end
      end
   end

   initial begin : stimulus
      int unsigned idle_pct;
      int          drain;
      queue_pixel(0, 0, 0, 0);
      queue_pixel(255, 255, 255, 0);
      queue_pixel(16, 128, 128, 0);
      queue_pixel(235, 128, 128, 0);
      queue_pixel(0, 128, 128, 0);
      queue_pixel(255, 128, 128, 0);
      queue_pixel(16, 0, 0, 0);
      queue_pixel(16, 255, 255, 0);
      queue_pixel(16, 0, 255, 0);
      queue_pixel(16, 255, 0, 0);
      queue_pixel(235, 0, 0, 0);
      queue_pixel(235, 255, 255, 0);
      queue_pixel(0, 255, 0, 0);
      queue_pixel(255, 0, 255, 0);
      queue_pixel(81, 90, 240, 0);
      queue_pixel(145, 54, 34, 0);
      queue_pixel(41, 240, 110, 0);
      queue_pixel(126, 128, 128, 0);
      queue_pixel(15, 127, 129, 0);
      queue_pixel(236, 129, 127, 0);
      queue_pixel(1, 254, 1, 0);
      queue_pixel(254, 1, 254, 0);
      queue_pixel(170, 85, 170, 0);
      queue_pixel(85, 170, 85, 0);
      for (int i = 0; i < 560; i++) begin
         case ((i / 140) % 4)
            0: idle_pct = 0;
            1: idle_pct = 79;
            2: idle_pct = 28;
            default: idle_pct = 0;
         endcase
         if ($urandom_range(99) < 60) begin
            queue_pixel($urandom_range(235, 16), $urandom_range(240, 16),
                        $urandom_range(240, 16), idle_pct);
         end else begin
            queue_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255),
                        idle_pct);
         end
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (pending_pixels.size() != 0 || start) @(posedge clock);
      drain = 0;
      while (gray_due.size() != 0 && drain < 1000) begin
         @(posedge clock);
         drain++;
      end
      repeat (10) @(posedge clock);
      if (gray_due.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", gray_due.size()));
      end
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("status: fail");
      $finish;
   end

endmodule
